// ===== design/bplpt_pkg.sv =====
// Shared types and constants for the button press and long-press tracker.
// Used by the lane, merge and top-level modules; no dependencies of its own.
`timescale 1ns / 1ps

package bplpt_pkg;

	// Field widths fixed by the item formats
	localparam int unsigned PIN_W   = 3;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned HOLD_W  = 16;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned ID_W    = 2;

	// Button modes
	localparam logic [MODE_W-1:0] MODE_RELEASED = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PRESSED  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LONG     = 2'd2;

	// Item kinds
	localparam logic KIND_POLL = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// Hold time after reset, in ms
	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd1000;

	// What one lane shows to the merge stage
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic               pend;
		logic [COUNT_W-1:0] count;
	} lane_status_t;

	// Per-lane update strobes from the merge stage
	typedef struct packed {
		logic poll;
		logic clear;
	} lane_ctrl_t;

	// One result beat
	typedef struct packed {
		logic [MODE_W-1:0]  button_state;
		logic               event_res;
		logic [COUNT_W-1:0] press_total;
		logic               any_pressed;
	} result_t;

endpackage

// ===== design/bplpt_lane.sv =====
// One button lane: edge detection, press counting, event flag and long-press timing.
// Depends on bplpt_pkg for widths, mode codes and the lane structs.
`timescale 1ns / 1ps

module bplpt_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bplpt_pkg::lane_ctrl_t             ctrl,
	input  logic                              level,
	input  logic [bplpt_pkg::TIME_W-1:0]      now_ms,
	input  logic [bplpt_pkg::HOLD_W-1:0]      long_press_ms,
	output bplpt_pkg::lane_status_t           status,
	output logic                              active_nx
);

	logic [bplpt_pkg::MODE_W-1:0]  mode_q;
	logic [bplpt_pkg::TIME_W-1:0]  start_q;
	logic [bplpt_pkg::COUNT_W-1:0] count_q;
	logic                          pend_q;
	logic                          prev_q;

	logic                          fall;
	logic [bplpt_pkg::MODE_W-1:0]  mode_edge;
	logic [bplpt_pkg::TIME_W-1:0]  start_edge;
	logic [bplpt_pkg::TIME_W-1:0]  elapsed;
	logic                          held_long;
	logic [bplpt_pkg::MODE_W-1:0]  mode_nx;

	// Falling edge takes the press time and enters pressed
	assign fall       = !level && prev_q;
	assign mode_edge  = fall ? bplpt_pkg::MODE_PRESSED : mode_q;
	assign start_edge = fall ? now_ms : start_q;

	// Wrapping hold time against the configured threshold
	assign elapsed   = now_ms - start_edge;
	assign held_long = (mode_edge == bplpt_pkg::MODE_PRESSED) &&
		(elapsed >= {{(bplpt_pkg::TIME_W-bplpt_pkg::HOLD_W){1'b0}}, long_press_ms});

	// A high level always releases
	always_comb begin
		if (level) begin
			mode_nx = bplpt_pkg::MODE_RELEASED;
		end else if (held_long) begin
			mode_nx = bplpt_pkg::MODE_LONG;
		end else begin
			mode_nx = mode_edge;
		end
	end

	// Advance the lane on a poll beat, drop the flag on a read of this lane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bplpt_pkg::MODE_RELEASED;
			start_q <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
			prev_q  <= 1'b1;
		end else if (ctrl.poll) begin
			mode_q  <= mode_nx;
			start_q <= start_edge;
			prev_q  <= level;
			if (fall) begin
				count_q <= count_q + 1'b1;
				pend_q  <= 1'b1;
			end
		end else if (ctrl.clear) begin
			pend_q <= 1'b0;
		end
	end

	assign status.mode  = mode_q;
	assign status.pend  = pend_q;
	assign status.count = count_q;

	// Mode after this beat, for the any-pressed flag
	assign active_nx = ctrl.poll ? (mode_nx != bplpt_pkg::MODE_RELEASED)
		: (mode_q != bplpt_pkg::MODE_RELEASED);

endmodule

// ===== design/bplpt_merge.sv =====
// Merge stage: decodes the beat into per-lane strobes and combines lane results.
// Depends on bplpt_pkg for the lane structs, kind codes and the result struct.
`timescale 1ns / 1ps

module bplpt_merge #(
	parameter int unsigned NUM_BUTTONS = 3
) (
	input  logic                            accept,
	input  logic                            kind,
	input  logic [bplpt_pkg::ID_W-1:0]      button_id,
	input  bplpt_pkg::lane_status_t         status [NUM_BUTTONS],
	input  logic [NUM_BUTTONS-1:0]          active_nx,
	output bplpt_pkg::lane_ctrl_t           ctrl [NUM_BUTTONS],
	output bplpt_pkg::result_t              result
);

	logic [NUM_BUTTONS-1:0] hit;

	// Select the lane a read names; id 0 and ids past the last lane match none
	always_comb begin
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			hit[b] = (kind == bplpt_pkg::KIND_READ) && ((b + 1) == int'(button_id));
			ctrl[b].poll  = accept && (kind == bplpt_pkg::KIND_POLL);
			ctrl[b].clear = accept && hit[b];
		end
	end

	// OR the selected lane into the result; polls report zeros in the lane fields
	always_comb begin
		result = '0;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			if (hit[b]) begin
				result.button_state = result.button_state | status[b].mode;
				result.event_res    = result.event_res    | status[b].pend;
				result.press_total  = result.press_total  | status[b].count;
			end
		end
		result.any_pressed = |active_nx;
	end

endmodule

// ===== design/button_press_long_press_tracker.sv =====
// Tracks NUM_BUTTONS active-low buttons, one lane per button, all updated in the
// same cycle by a poll beat. Each accepted beat, poll or read, gives one result
// beat from an output register in the next cycle, so a new beat is taken every
// clock while the result side does not stall; the request side stalls only when
// the output register is full and stalled. A read of button 1 to 3 returns that
// button's mode, press count and event flag and clears the flag; id 0 or an id
// beyond the last button returns zeros. any_pressed reflects the state after the
// beat. long_press_ms resets to 1000; the user writes it via wr_en/wr_data only
// while idle, not enforced. Buttons beyond the 3-bit pin field read as pressed.
`timescale 1ns / 1ps

module button_press_long_press_tracker #(
	parameter int unsigned NUM_BUTTONS = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 wr_en,
	input  logic [bplpt_pkg::HOLD_W-1:0]         wr_data,
	// request channel
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic                                 kind,
	input  logic [bplpt_pkg::PIN_W-1:0]          pin_levels,
	input  logic [bplpt_pkg::TIME_W-1:0]         now_ms,
	input  logic [bplpt_pkg::ID_W-1:0]           button_id,
	// result channel
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic [bplpt_pkg::MODE_W-1:0]         button_state,
	output logic                                 event_res,
	output logic [bplpt_pkg::COUNT_W-1:0]        press_total,
	output logic                                 any_pressed
);

	logic [bplpt_pkg::HOLD_W-1:0] hold_q;
	logic                         res_valid_q;
	bplpt_pkg::result_t           res_q;
	logic                         accept;

	bplpt_pkg::lane_ctrl_t        ctrl   [NUM_BUTTONS];
	bplpt_pkg::lane_status_t      status [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0]       active_nx;
	logic [NUM_BUTTONS-1:0]       level;
	bplpt_pkg::result_t           result;

	// Hold time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= bplpt_pkg::HOLD_RESET;
		end else if (wr_en) begin
			hold_q <= wr_data;
		end
	end

	// Take a beat whenever the output register is free or being emptied
	assign req_stall = res_valid_q && res_stall;
	assign accept    = req_valid && !req_stall;

	// One lane per button
	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
		if (b < bplpt_pkg::PIN_W) begin : g_pin
			assign level[b] = pin_levels[b];
		end else begin : g_nopin
			assign level[b] = 1'b0;
		end

		bplpt_lane u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl[b]),
			.level         (level[b]),
			.now_ms        (now_ms),
			.long_press_ms (hold_q),
			.status        (status[b]),
			.active_nx     (active_nx[b])
		);
	end

	bplpt_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.accept    (accept),
		.kind      (kind),
		.button_id (button_id),
		.status    (status),
		.active_nx (active_nx),
		.ctrl      (ctrl),
		.result    (result)
	);

	// Output register: load on accept, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= result;
		end
	end

	assign res_valid    = res_valid_q;
	assign button_state = res_q.button_state;
	assign event_res    = res_q.event_res;
	assign press_total  = res_q.press_total;
	assign any_pressed  = res_q.any_pressed;

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for button_press_long_press_tracker: poll and read beats with
// random pin levels, time jumps and hold-time settings, checked against an in-bench
// tracker of every button. Depends on bplpt_pkg and the tracker RTL only.
`timescale 1ns / 1ps

module testbench;

	localparam int BUTTONS         = 3;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int PHASE_BEATS     = 290;

	typedef struct packed {
		logic                         kind;
		logic [bplpt_pkg::PIN_W-1:0]  pins;
		logic [bplpt_pkg::TIME_W-1:0] now;
		logic [bplpt_pkg::ID_W-1:0]   id;
	} button_beat_t;

	// DUT signals, all inputs known from time zero
	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          wr_en      = 1'b0;
	logic [bplpt_pkg::HOLD_W-1:0]  wr_data    = '0;
	logic                          req_valid  = 1'b0;
	logic                          req_stall;
	logic                          kind       = bplpt_pkg::KIND_POLL;
	logic [bplpt_pkg::PIN_W-1:0]   pin_levels = '1;
	logic [bplpt_pkg::TIME_W-1:0]  now_ms     = '0;
	logic [bplpt_pkg::ID_W-1:0]    button_id  = '0;
	logic                          res_valid;
	logic                          res_stall  = 1'b0;
	logic [bplpt_pkg::MODE_W-1:0]  button_state;
	logic                          event_res;
	logic [bplpt_pkg::COUNT_W-1:0] press_total;
	logic                          any_pressed;

	button_press_long_press_tracker #(.NUM_BUTTONS(BUTTONS)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_data      (wr_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.kind         (kind),
		.pin_levels   (pin_levels),
		.now_ms       (now_ms),
		.button_id    (button_id),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.button_state (button_state),
		.event_res    (event_res),
		.press_total  (press_total),
		.any_pressed  (any_pressed)
	);

	// Tracker state mirrored in the bench
	logic [bplpt_pkg::MODE_W-1:0]  mode_now    [BUTTONS];
	logic [bplpt_pkg::TIME_W-1:0]  press_at    [BUTTONS];
	logic [bplpt_pkg::COUNT_W-1:0] press_tally [BUTTONS];
	logic                          ev_flag     [BUTTONS];
	logic                          level_was   [BUTTONS];
	logic [bplpt_pkg::HOLD_W-1:0]  hold_ms;

	// Stimulus side
	button_beat_t                 pending_beats [$];
	logic [bplpt_pkg::TIME_W-1:0] clock_ms      = '0;
	logic [bplpt_pkg::HOLD_W-1:0] gen_hold      = bplpt_pkg::HOLD_RESET;
	int                           queued_count  = 0;
	logic                         flood         = 1'b0;
	int                           hold_requests = 0;

	// Driver and receiver state
	button_beat_t next_beat;
	int           burst_left  = 0;
	int           gap_left    = 0;
	int           hold_served = 0;
	int           hold_left   = 0;
	int           stall_style = 0;
	int           style_left  = 0;

	// Checking side
	bplpt_pkg::result_t due_reports [$];
	bplpt_pkg::result_t want;
	logic               req_taken   = 1'b0;
	int                 error_count = 0;
	int                 cycle_count = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Apply one accepted beat to the mirrored buttons and return the report it gives
	function automatic bplpt_pkg::result_t advance_buttons(input button_beat_t b);
		bplpt_pkg::result_t           r;
		logic                         lvl;
		logic [bplpt_pkg::TIME_W-1:0] held_for;
		logic [1:0]                   k;
		r = '0;
		if (b.kind == bplpt_pkg::KIND_POLL) begin
			for (int i = 0; i < BUTTONS; i++) begin
				lvl = b.pins[i];
				if (!lvl && level_was[i]) begin
					press_at[i]    = b.now;
					mode_now[i]    = bplpt_pkg::MODE_PRESSED;
					ev_flag[i]     = 1'b1;
					press_tally[i] = press_tally[i] + 1'b1;
				end
				held_for = b.now - press_at[i];
				if (mode_now[i] == bplpt_pkg::MODE_PRESSED && held_for >= {16'd0, hold_ms})
					mode_now[i] = bplpt_pkg::MODE_LONG;
				if (lvl)
					mode_now[i] = bplpt_pkg::MODE_RELEASED;
				level_was[i] = lvl;
			end
		end else if (b.id >= 1 && b.id <= BUTTONS) begin
			k = b.id - 1'b1;
			r.button_state = mode_now[k];
			r.event_res    = ev_flag[k];
			r.press_total  = press_tally[k];
			ev_flag[k]     = 1'b0;
		end
		for (int i = 0; i < BUTTONS; i++) begin
			if (mode_now[i] != bplpt_pkg::MODE_RELEASED)
				r.any_pressed = 1'b1;
		end
		return r;
	endfunction

	// Print one line per mismatch and count it
	task automatic report_mismatch(input string field,
			input logic [bplpt_pkg::COUNT_W-1:0] seen,
			input logic [bplpt_pkg::COUNT_W-1:0] wanted);
		$display("[%0t] %s mismatch: got 0x%0h, want 0x%0h", $time, field, seen, wanted);
		error_count++;
	endtask

	// Stimulus helpers
	task automatic add_beat(input logic k, input logic [bplpt_pkg::PIN_W-1:0] p,
			input logic [bplpt_pkg::TIME_W-1:0] t, input logic [bplpt_pkg::ID_W-1:0] id);
		button_beat_t b;
		b.kind = k;
		b.pins = p;
		b.now  = t;
		b.id   = id;
		pending_beats.push_back(b);
		queued_count++;
	endtask

	task automatic queue_poll(input logic [bplpt_pkg::PIN_W-1:0] p);
		add_beat(bplpt_pkg::KIND_POLL, p, clock_ms, 2'($urandom_range(0, 3)));
	endtask

	task automatic queue_read(input logic [bplpt_pkg::ID_W-1:0] id);
		add_beat(bplpt_pkg::KIND_READ, 3'($urandom_range(0, 7)), $urandom(), id);
	endtask

	function automatic logic [bplpt_pkg::ID_W-1:0] pick_id();
		if ($urandom_range(0, 7) == 0)
			return '0;
		return 2'($urandom_range(1, BUTTONS));
	endfunction

	// Move time on: mostly small steps, now and then a jump or a spot near the wrap
	task automatic step_clock();
		case ($urandom_range(0, 15))
			0: clock_ms = $urandom();
			1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * int'(gen_hold) + 8);
			default: clock_ms = clock_ms + $urandom_range(0, int'(gen_hold) / 3 + 3);
		endcase
	endtask

	// One press of a random set of buttons: held over a few polls, then let go
	task automatic queue_press_run();
		logic [bplpt_pkg::PIN_W-1:0]  held;
		logic [bplpt_pkg::PIN_W-1:0]  p;
		logic [bplpt_pkg::TIME_W-1:0] t0;
		int                           polls;
		int                           idx;
		held  = 3'($urandom_range(1, 7));
		polls = $urandom_range(1, 8);
		step_clock();
		t0 = clock_ms;
		for (int j = 0; j < polls; j++) begin
			if (j > 0) begin
				// land right on the hold boundary now and then
				if ($urandom_range(0, 3) == 0)
					clock_ms = t0 + gen_hold - $urandom_range(0, 1);
				else
					step_clock();
			end
			p = ~held;
			if ($urandom_range(0, 5) == 0) begin
				idx    = $urandom_range(0, 2);
				p[idx] = ~p[idx];
			end
			queue_poll(p);
			if ($urandom_range(0, 2) == 0)
				queue_read(pick_id());
		end
		step_clock();
		if ($urandom_range(0, 3) == 0)
			queue_poll(3'($urandom_range(0, 7)));
		else
			queue_poll('1);
		for (int j = $urandom_range(0, 3); j > 0; j--)
			queue_read(pick_id());
	endtask

	task automatic queue_noise();
		if ($urandom_range(0, 1) == 0) begin
			step_clock();
			queue_poll(3'($urandom_range(0, 7)));
		end else begin
			queue_read(2'($urandom_range(0, 3)));
		end
	endtask

	task automatic random_phase(input int n);
		int start;
		start = queued_count;
		while (queued_count - start < n) begin
			if ($urandom_range(0, 9) < 7)
				queue_press_run();
			else
				queue_noise();
		end
	endtask

	task automatic write_hold(input logic [bplpt_pkg::HOLD_W-1:0] v);
		@(negedge clk);
		wr_en   <= 1'b1;
		wr_data <= v;
		@(negedge clk);
		wr_en   <= 1'b0;
		gen_hold = v;
	endtask

	// Hold until every beat is sent and every report is back, then let the block settle
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_beats.size() != 0 || req_valid || due_reports.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	// Stimulus: directed beats, then random phases at several hold times
	initial begin
		logic [bplpt_pkg::HOLD_W-1:0] hold_plan [6];
		hold_plan[0] = '0;
		hold_plan[1] = '1;
		hold_plan[2] = 16'd1;
		hold_plan[3] = 16'($urandom());
		hold_plan[4] = 16'($urandom_range(2, 50));
		hold_plan[5] = bplpt_pkg::HOLD_RESET;
		hold_ms = bplpt_pkg::HOLD_RESET;
		for (int i = 0; i < BUTTONS; i++) begin
			mode_now[i]    = bplpt_pkg::MODE_RELEASED;
			press_at[i]    = '0;
			press_tally[i] = '0;
			ev_flag[i]     = 1'b0;
			level_was[i]   = 1'b1;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reads straight out of reset, every id
		for (int i = 0; i <= BUTTONS; i++)
			queue_read(2'(i));
		// all pressed at once, reads report and clear the event flags
		clock_ms = 32'd0;
		queue_poll(3'b111);
		clock_ms = 32'd100;
		queue_poll(3'b000);
		queue_read(2'd1);
		queue_read(2'd2);
		queue_read(2'd3);
		queue_read(2'd1);
		// one short of the hold time, then exactly on it
		clock_ms = 32'd1099;
		queue_poll(3'b000);
		clock_ms = 32'd1100;
		queue_poll(3'b000);
		queue_read(2'd3);
		clock_ms = 32'd1200;
		queue_poll(3'b101);
		queue_read(2'd2);
		// press across the time wrap
		clock_ms = 32'hFFFF_FFF0;
		queue_poll(3'b111);
		clock_ms = 32'hFFFF_FFFF;
		queue_poll(3'b110);
		clock_ms = 32'h0000_03E6;
		queue_poll(3'b110);
		clock_ms = 32'h0000_03E7;
		queue_poll(3'b110);
		queue_read(2'd1);
		queue_read(2'd0);
		clock_ms = 32'h8000_0000;
		queue_poll(3'b011);
		clock_ms = 32'h8000_0001;
		queue_poll(3'b111);
		queue_read(2'd3);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			write_hold(hold_plan[p]);
			if (p == 0) begin
				// zero hold: long press on the falling edge itself
				clock_ms = 32'd5000;
				queue_poll(3'b110);
				queue_read(2'd1);
				queue_poll(3'b111);
			end
			if (p == 2) begin
				// receiver holds off while the sender keeps offering beats
				flood = 1'b1;
				hold_requests++;
			end
			random_phase(PHASE_BEATS);
			wait_idle();
			flood = 1'b0;
		end

		if (error_count == 0)
			$display("button_press_long_press_tracker verification clean");
		else
			$display("button_press_long_press_tracker verification failed");
		$finish;
	end

	// Driver: hold a beat until taken, send in bursts with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_taken) begin
			if (gap_left != 0 && !flood) begin
				gap_left  <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (pending_beats.size() != 0) begin
				next_beat = pending_beats.pop_front();
				req_valid  <= 1'b1;
				kind       <= next_beat.kind;
				pin_levels <= next_beat.pins;
				now_ms     <= next_beat.now;
				button_id  <= next_beat.id;
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Receiver: long hold-off on request, otherwise a changing stall pattern
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left   <= HOLD_OFF_CYCLES;
			res_stall   <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			if (style_left == 0) begin
				stall_style <= $urandom_range(0, 3);
				style_left  <= $urandom_range(20, 120);
			end else begin
				style_left <= style_left - 1;
			end
			case (stall_style)
				0: res_stall <= 1'b0;
				1: res_stall <= ($urandom_range(0, 3) == 0);
				2: res_stall <= ($urandom_range(0, 1) == 0);
				default: res_stall <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	// Monitor: check reports in order, track hold writes, predict each taken beat
	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (due_reports.size() == 0) begin
					report_mismatch("unexpected result beat", '0, '0);
				end else begin
					want = due_reports.pop_front();
					if (button_state !== want.button_state)
						report_mismatch("button_state", 32'(button_state),
							32'(want.button_state));
					if (event_res !== want.event_res)
						report_mismatch("event_res", 32'(event_res), 32'(want.event_res));
					if (press_total !== want.press_total)
						report_mismatch("press_total", press_total, want.press_total);
					if (any_pressed !== want.any_pressed)
						report_mismatch("any_pressed", 32'(any_pressed),
							32'(want.any_pressed));
				end
			end
			if (wr_en)
				hold_ms = wr_data;
			if (req_valid && !req_stall)
				due_reports.push_back(advance_buttons({kind, pin_levels, now_ms, button_id}));
			req_taken <= req_valid && !req_stall;
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("button_press_long_press_tracker verification failed");
			$finish;
		end
	end

endmodule
